// ===== rtl/core/occupancy_grid_ray_mark_and_cast_assert.svh =====
// Assertion macros shared by the occupancy grid checker.
// Expects clk and rst_n in the scope of each use.
`ifndef OCCUPANCY_GRID_RAY_MARK_AND_CAST_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_MARK_AND_CAST_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define OGR_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define OGR_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/core/ogr_pkg.sv =====
// Shared types, constants and point arithmetic for the occupancy grid block.
// No dependencies.
package ogr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int RW = 20;  // range and distance fields
  localparam int SW = 16;  // ray step
  localparam int MW = 10;  // map size
  localparam int OW = 22;  // origin
  localparam int VW = 16;  // direction
  localparam int DW = 21;  // running distance
  localparam int PW = 38;  // point, origin * 2^15 + dir * span
  localparam int XW = 3;   // register index

  localparam logic [RW-1:0] SCAN_MIN_RST = 20'd256;
  localparam logic [RW-1:0] SCAN_MAX_RST = 20'd153600;
  localparam logic [RW-1:0] CAST_MIN_RST = 20'd256;
  localparam logic [RW-1:0] CAST_MAX_RST = 20'd153600;
  localparam logic [SW-1:0] STEP_RST     = 16'd128;
  localparam logic [MW-1:0] MAP_W_RST    = 10'd400;
  localparam logic [MW-1:0] MAP_H_RST    = 10'd400;

  typedef enum logic [1:0] {
    CELL_UNKNOWN  = 2'd0,
    CELL_FREE     = 2'd1,
    CELL_OCCUPIED = 2'd2
  } cell_t;

  typedef enum logic [XW-1:0] {
    REG_SCAN_MIN = 3'd0,
    REG_SCAN_MAX = 3'd1,
    REG_CAST_MIN = 3'd2,
    REG_CAST_MAX = 3'd3,
    REG_STEP     = 3'd4,
    REG_MAP_W    = 3'd5,
    REG_MAP_H    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                 cast;
    logic                 hit;
    logic signed [PW-1:0] ox;
    logic signed [PW-1:0] oy;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    logic signed [PW-1:0] hx;
    logic signed [PW-1:0] hy;
    logic [DW-1:0]        dist0;
    logic [DW-1:0]        limit;
    logic [SW-1:0]        step;
    logic [MW-1:0]        effw;
    logic [MW-1:0]        effh;
  } cmd_t;

  function automatic logic signed [PW-1:0] point(input logic signed [OW-1:0] org,
                                                 input logic signed [VW-1:0] dir,
                                                 input logic [DW-1:0] span);
    logic signed [PW-1:0] o;
    logic signed [PW-1:0] m;
    o = org;
    o = o <<< 15;
    m = dir * $signed({1'b0, span});
    return o + m;
  endfunction

endpackage

// ===== rtl/core/ogr_front.sv =====
// Front end: configuration registers, input stage, beam classification and command queue.
// Depends on ogr_pkg.
module ogr_front #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ogr_pkg::XW-1:0]        cfg_index,
  input  logic [ogr_pkg::RW-1:0]        cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_action,
  input  logic signed [ogr_pkg::OW-1:0] in_origin_x,
  input  logic signed [ogr_pkg::OW-1:0] in_origin_y,
  input  logic signed [ogr_pkg::VW-1:0] in_dir_x,
  input  logic signed [ogr_pkg::VW-1:0] in_dir_y,
  input  logic [ogr_pkg::RW-1:0]        in_beam_range,
  input  logic                          in_range_finite,
  input  logic                          clearing,
  output logic                          cmd_valid,
  output ogr_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  logic [ogr_pkg::RW-1:0] scan_min_r, scan_max_r, cast_min_r, cast_max_r;
  logic [ogr_pkg::SW-1:0] step_cfg_r;
  logic [ogr_pkg::MW-1:0] map_w_r, map_h_r;

  logic                          s_valid_r;
  logic                          s_action_r;
  logic signed [ogr_pkg::OW-1:0] s_ox_r, s_oy_r;
  logic signed [ogr_pkg::VW-1:0] s_dx_r, s_dy_r;
  logic [ogr_pkg::RW-1:0]        s_beam_r;
  logic                          s_fin_r;

  ogr_pkg::cmd_t q_mem_r [2];
  logic          q_wp_r, q_rp_r;
  logic [1:0]    q_cnt_r;
  logic          q_full;

  logic                   accept, s_move;
  logic [ogr_pkg::SW-1:0] step;
  logic [ogr_pkg::RW-1:0] range;
  logic                   hit;
  logic [ogr_pkg::RW-1:0] mlimit;
  logic [ogr_pkg::DW-1:0] first;
  ogr_pkg::cmd_t          c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_min_r <= ogr_pkg::SCAN_MIN_RST;
      scan_max_r <= ogr_pkg::SCAN_MAX_RST;
      cast_min_r <= ogr_pkg::CAST_MIN_RST;
      cast_max_r <= ogr_pkg::CAST_MAX_RST;
      step_cfg_r <= ogr_pkg::STEP_RST;
      map_w_r    <= ogr_pkg::MAP_W_RST;
      map_h_r    <= ogr_pkg::MAP_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogr_pkg::REG_SCAN_MIN: scan_min_r <= cfg_wdata;
        ogr_pkg::REG_SCAN_MAX: scan_max_r <= cfg_wdata;
        ogr_pkg::REG_CAST_MIN: cast_min_r <= cfg_wdata;
        ogr_pkg::REG_CAST_MAX: cast_max_r <= cfg_wdata;
        ogr_pkg::REG_STEP:     step_cfg_r <= cfg_wdata[ogr_pkg::SW-1:0];
        ogr_pkg::REG_MAP_W:    map_w_r    <= cfg_wdata[ogr_pkg::MW-1:0];
        ogr_pkg::REG_MAP_H:    map_h_r    <= cfg_wdata[ogr_pkg::MW-1:0];
        default: ;
      endcase
    end
  end

  assign q_full  = (q_cnt_r == 2'd2);
  assign in_full = clearing | (s_valid_r & q_full);
  assign accept  = in_push & ~in_full;
  assign s_move  = s_valid_r & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (s_move) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_action_r <= in_action;
      s_ox_r     <= in_origin_x;
      s_oy_r     <= in_origin_y;
      s_dx_r     <= in_dir_x;
      s_dy_r     <= in_dir_y;
      s_beam_r   <= in_beam_range;
      s_fin_r    <= in_range_finite;
    end
  end

  // Classify the beam and precompute start, step and hit points.
  always_comb begin
    step  = (step_cfg_r == '0) ? ogr_pkg::SW'(1) : step_cfg_r;
    range = s_fin_r ? s_beam_r : scan_max_r;
    hit   = s_fin_r && (s_beam_r >= scan_min_r) && (s_beam_r < scan_max_r);
    if (hit) begin
      mlimit = (range != '0) ? range - ogr_pkg::RW'(1) : '0;
    end else begin
      mlimit = (range < scan_max_r) ? range : scan_max_r;
    end
    first   = s_action_r ? ogr_pkg::DW'(cast_min_r) : ogr_pkg::DW'(step);
    c.cast  = s_action_r;
    c.hit   = hit;
    c.ox    = ogr_pkg::point(s_ox_r, '0, '0);
    c.oy    = ogr_pkg::point(s_oy_r, '0, '0);
    c.px    = ogr_pkg::point(s_ox_r, s_dx_r, first);
    c.py    = ogr_pkg::point(s_oy_r, s_dy_r, first);
    c.sx    = ogr_pkg::point('0, s_dx_r, ogr_pkg::DW'(step));
    c.sy    = ogr_pkg::point('0, s_dy_r, ogr_pkg::DW'(step));
    c.hx    = ogr_pkg::point(s_ox_r, s_dx_r, ogr_pkg::DW'(s_beam_r));
    c.hy    = ogr_pkg::point(s_oy_r, s_dy_r, ogr_pkg::DW'(s_beam_r));
    c.dist0 = first;
    c.limit = s_action_r ? ogr_pkg::DW'(cast_max_r) : ogr_pkg::DW'(mlimit);
    c.step  = step;
    c.effw  = (32'(map_w_r) < MAX_WIDTH) ? map_w_r : ogr_pkg::MW'(MAX_WIDTH);
    c.effh  = (32'(map_h_r) < MAX_HEIGHT) ? map_h_r : ogr_pkg::MW'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (s_move) begin
      q_mem_r[q_wp_r] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (s_move) begin
        q_wp_r <= ~q_wp_r;
      end
      if (cmd_pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(s_move) - 2'(cmd_pop);
    end
  end

  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd       = q_mem_r[q_rp_r];

endmodule

// ===== rtl/core/ogr_outq.sv =====
// Two-entry result queue between the ray walker and the result port.
// Depends on ogr_pkg.
module ogr_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [ogr_pkg::RW-1:0] push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output logic [ogr_pkg::RW-1:0] pop_data
);

  logic [ogr_pkg::RW-1:0] mem_r [2];
  logic                   wp_r, rp_r;
  logic [1:0]             cnt_r;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  assign pop_data = mem_r[rp_r];

endmodule

// ===== rtl/core/ogr_back.sv =====
// Back end: cell store with clearing pass and the ray walker for mark and cast.
// Depends on ogr_pkg.
module ogr_back #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  ogr_pkg::cmd_t          cmd,
  output logic                   cmd_pop,
  output logic                   clearing,
  output logic                   res_push,
  output logic [ogr_pkg::RW-1:0] res_data,
  input  logic                   res_full
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_ORG   = 8'b0000_0100,
    ST_STEP  = 8'b0000_1000,
    ST_HIT   = 8'b0001_0000,
    ST_CRD   = 8'b0010_0000,
    ST_CWAIT = 8'b0100_0000,
    ST_RES   = 8'b1000_0000
  } state_t;

  ogr_pkg::cell_t mem [DEPTH];

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic signed [ogr_pkg::PW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [ogr_pkg::DW-1:0]       dist_r, dist_nxt;
  logic [ogr_pkg::RW-1:0]       res_r, res_nxt;
  ogr_pkg::cell_t               rd_r;

  logic signed [ogr_pkg::PW-1:0] qx, qy;
  logic [13:0]                   col, row;
  logic                          on_map;
  logic [2*ogr_pkg::MW-1:0]      lin;
  logic [AW-1:0]                 idx;
  logic                          we, re;
  logic [AW-1:0]                 wa;
  ogr_pkg::cell_t                wd;
  logic                          past_limit;

  // Point to cell for the point that the current state looks at.
  always_comb begin
    if (state_r == ST_ORG) begin
      qx = cmd.ox;
      qy = cmd.oy;
    end else if (state_r == ST_HIT) begin
      qx = cmd.hx;
      qy = cmd.hy;
    end else begin
      qx = cur_x_r;
      qy = cur_y_r;
    end
    col    = qx[36:23];
    row    = qy[36:23];
    on_map = ~qx[ogr_pkg::PW-1] && ~qy[ogr_pkg::PW-1] &&
             (col < 14'(cmd.effw)) && (row < 14'(cmd.effh));
    lin    = row[ogr_pkg::MW-1:0] * cmd.effw + (2*ogr_pkg::MW)'(col[ogr_pkg::MW-1:0]);
    idx    = AW'(lin);
  end

  assign past_limit = (dist_r > cmd.limit);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    dist_nxt  = dist_r;
    res_nxt   = res_r;
    we        = 1'b0;
    re        = 1'b0;
    wa        = idx;
    wd        = ogr_pkg::CELL_FREE;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = ogr_pkg::CELL_UNKNOWN;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ST_ORG;
        end
      end
      ST_ORG: begin
        cur_x_nxt = cmd.px;
        cur_y_nxt = cmd.py;
        dist_nxt  = cmd.dist0;
        if (cmd.cast) begin
          if (on_map) begin
            state_nxt = ST_CRD;
          end else begin
            res_nxt   = cmd.limit[ogr_pkg::RW-1:0];
            state_nxt = ST_RES;
          end
        end else if (on_map) begin
          we        = 1'b1;
          state_nxt = ST_STEP;
        end else begin
          cmd_pop   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (past_limit) begin
          if (cmd.hit) begin
            state_nxt = ST_HIT;
          end else begin
            cmd_pop   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          we        = on_map;
          cur_x_nxt = cur_x_r + cmd.sx;
          cur_y_nxt = cur_y_r + cmd.sy;
          dist_nxt  = dist_r + ogr_pkg::DW'(cmd.step);
        end
      end
      ST_HIT: begin
        we        = on_map;
        wd        = ogr_pkg::CELL_OCCUPIED;
        cmd_pop   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CRD: begin
        if (past_limit || !on_map) begin
          res_nxt   = cmd.limit[ogr_pkg::RW-1:0];
          state_nxt = ST_RES;
        end else begin
          re        = 1'b1;
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (rd_r == ogr_pkg::CELL_OCCUPIED) begin
          res_nxt   = dist_r[ogr_pkg::RW-1:0];
          state_nxt = ST_RES;
        end else if (rd_r == ogr_pkg::CELL_UNKNOWN) begin
          res_nxt   = cmd.limit[ogr_pkg::RW-1:0];
          state_nxt = ST_RES;
        end else begin
          cur_x_nxt = cur_x_r + cmd.sx;
          cur_y_nxt = cur_y_r + cmd.sy;
          dist_nxt  = dist_r + ogr_pkg::DW'(cmd.step);
          state_nxt = ST_CRD;
        end
      end
      ST_RES: begin
        if (!res_full) begin
          res_push  = 1'b1;
          cmd_pop   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    dist_r  <= dist_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[idx];
    end
  end

  assign clearing = (state_r == ST_CLEAR);
  assign res_data = res_r;

endmodule

// ===== rtl/core/occupancy_grid_ray_mark_and_cast.sv =====
// Top level of the occupancy grid ray marker and caster.
// Depends on ogr_pkg, ogr_front, ogr_back and ogr_outq.
//
//   channel  handshake              payload
//   input    in_push / in_full      in_action .. in_range_finite
//   result   out_pop / out_empty    out_measured_range
//   config   cfg_we                 cfg_index, cfg_wdata
//
// After reset a clearing pass writes every cell unknown, one per cycle, with in_full high.
// A mark does one cell write per step, one more on a hit; in a cast each step is a store read then a check.
// The walker handles one item at a time; a two-entry command queue and a
// two-entry result queue let input and output stall on their own.
module occupancy_grid_ray_mark_and_cast #(
  parameter int MAX_WIDTH  = ogr_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = ogr_pkg::MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ogr_pkg::XW-1:0]        cfg_index,
  input  logic [ogr_pkg::RW-1:0]        cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_action,
  input  logic signed [ogr_pkg::OW-1:0] in_origin_x,
  input  logic signed [ogr_pkg::OW-1:0] in_origin_y,
  input  logic signed [ogr_pkg::VW-1:0] in_dir_x,
  input  logic signed [ogr_pkg::VW-1:0] in_dir_y,
  input  logic [ogr_pkg::RW-1:0]        in_beam_range,
  input  logic                          in_range_finite,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ogr_pkg::RW-1:0]        out_measured_range
);

  logic                   clearing;
  logic                   cmd_valid, cmd_pop;
  ogr_pkg::cmd_t          cmd;
  logic                   res_push, res_full;
  logic [ogr_pkg::RW-1:0] res_data;

  ogr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_beam_range  (in_beam_range),
    .in_range_finite(in_range_finite),
    .clearing       (clearing),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  ogr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .clearing (clearing),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  ogr_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .full     (res_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .pop_data (out_measured_range)
  );

endmodule

// ===== rtl/core/ogr_checker.sv =====
// Port-level checker for the occupancy grid block, bound to the top level.
// Depends on ogr_pkg and occupancy_grid_ray_mark_and_cast_assert.svh.
`include "occupancy_grid_ray_mark_and_cast_assert.svh"

module ogr_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_full,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic [ogr_pkg::RW-1:0] out_measured_range
);

  `OGR_ASSERT_SAME(a_clear_blocks_input, !$past(rst_n), in_full, "input open during clearing")
  `OGR_ASSERT_SAME(a_no_result_after_reset, !$past(rst_n), out_empty, "result right after reset")
  `OGR_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop, !out_empty, "result dropped")
  `OGR_ASSERT_NEXT(a_result_stable, !out_empty && !out_pop, $stable(out_measured_range), "result changed")

endmodule

bind occupancy_grid_ray_mark_and_cast ogr_checker u_chk (.*);
